// File: rtl/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types, constants and helpers of the substring search matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ssm_pkg;

  // Default sizes
  localparam int NeedleMaxDef  = 16;
  localparam int OffsetBitsDef = 32;

  // Fixed field widths
  localparam int ByteW      = 8;
  localparam int OffsetW    = 32;
  localparam int CfgDataW   = 64;
  localparam int CfgIndexW  = 3;
  localparam int NeedleLenW = 5;
  localparam int NeedleRegs = 16;  // needle bytes held in the two 64-bit registers

  // Character constants
  localparam logic [ByteW-1:0] AsciiUpA     = 8'h41;
  localparam logic [ByteW-1:0] AsciiUpZ     = 8'h5A;
  localparam logic [ByteW-1:0] AsciiCaseGap = 8'h20;
  localparam logic [ByteW-1:0] AsciiNul     = 8'h00;

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CfgNeedleLo  = 3'd0,
    CfgNeedleHi  = 3'd1,
    CfgNeedleLen = 3'd2,
    CfgFoldCase  = 3'd3,
    CfgStopNul   = 3'd4
  } cfg_idx_t;

  // Fold ASCII upper case to lower case
  function automatic logic [ByteW-1:0] fold_byte(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] r;
    r = c;
    if (c >= AsciiUpA && c <= AsciiUpZ) begin
      r = c + AsciiCaseGap;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ssm_if.sv
// ----------------------------------------------------------------------------
// ssm_if
// Valid/ready channels of the substring search matcher.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssm_in_if
  import ssm_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] haystack_byte;
  logic             last_byte;

  modport source (output valid, output haystack_byte, output last_byte, input ready);
  modport sink   (input valid, input haystack_byte, input last_byte, output ready);
endinterface

interface ssm_out_if
  import ssm_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               found;
  logic [OffsetW-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

`default_nettype wire

// File: rtl/substring_search_matcher.sv
// ----------------------------------------------------------------------------
// substring_search_matcher
// Streaming first-occurrence substring search over a byte stream.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+-----------------------------------------
//   in_if   | in  | valid/ready   | haystack_byte[7:0], last_byte
//   out_if  | out | valid/ready   | found, match_offset[31:0]
//   cfg_*   | in  | write enable  | cfg_index[2:0], cfg_data[63:0]
//
// One haystack byte per cycle while the output is not stalled. A byte
// passes the input register, then window shift, parallel compare and
// count update write the result register, with back to back throughput.
// Reset (rst_n low, synchronous) clears valid flags, config (string mode on), count and search flag.
// The input is held only while the input register is full and a result is
// stalled at the output; a search gives at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module substring_search_matcher
  import ssm_pkg::*;
#(
  parameter int NEEDLE_MAX  = NeedleMaxDef,
  parameter int OFFSET_BITS = OffsetBitsDef
) (
  input  wire                  clk,
  input  wire                  rst_n,
  ssm_in_if.sink               in_if,
  ssm_out_if.source            out_if,
  input  wire                  cfg_we,
  input  wire [CfgIndexW-1:0]  cfg_index,
  input  wire [CfgDataW-1:0]   cfg_data
);

  localparam int LenW = $clog2(NEEDLE_MAX + 1);
  // Count saturation point; a 64-bit count never advances
  localparam logic [OFFSET_BITS-1:0] CountMax = (OFFSET_BITS == 64) ? '0 : '1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CfgDataW-1:0]   needle_lo_r;
  logic [CfgDataW-1:0]   needle_hi_r;
  logic [NeedleLenW-1:0] needle_len_r;
  logic                  fold_r;
  logic                  nul_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_lo_r  <= '0;
      needle_hi_r  <= '0;
      needle_len_r <= '0;
      fold_r       <= 1'b0;
      nul_r        <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CfgNeedleLo:  needle_lo_r  <= cfg_data;
        CfgNeedleHi:  needle_hi_r  <= cfg_data;
        CfgNeedleLen: needle_len_r <= cfg_data[NeedleLenW-1:0];
        CfgFoldCase:  fold_r       <= cfg_data[0];
        CfgStopNul:   nul_r        <= cfg_data[0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Needle setup: effective length and a right-aligned needle with a care
  // mask, so the per-byte compare is one equality per window position.
  // Registered from the config registers. The user keeps config changes to idle only; the block does not enforce this.
  // --------------------------------------------------------------------------
  logic [ByteW-1:0] nbytes   [NeedleRegs];
  logic [LenW-1:0]  len_cap;
  logic [LenW-1:0]  eff_len;
  logic [LenW-1:0]  eff_len_r;
  logic [ByteW-1:0] align_nxt [NEEDLE_MAX];
  logic [ByteW-1:0] align_r   [NEEDLE_MAX];
  logic [NEEDLE_MAX-1:0] care_nxt;
  logic [NEEDLE_MAX-1:0] care_r;

  always_comb begin
    int j;
    for (int k = 0; k < NeedleRegs; k++) begin
      if (k < 8) begin
        nbytes[k] = needle_lo_r[8*k +: 8];
      end else begin
        nbytes[k] = needle_hi_r[8*(k-8) +: 8];
      end
    end

    if (int'(needle_len_r) > NEEDLE_MAX) begin
      len_cap = LenW'(NEEDLE_MAX);
    end else begin
      len_cap = LenW'(needle_len_r);
    end

    // String mode: a needle ends at its first NUL byte
    eff_len = len_cap;
    if (nul_r) begin
      for (int k = NEEDLE_MAX - 1; k >= 0; k--) begin
        if (k < int'(len_cap)) begin
          if (k >= NeedleRegs) begin
            eff_len = LenW'(k);
          end else if (nbytes[k[3:0]] == AsciiNul) begin
            eff_len = LenW'(k);
          end
        end
      end
    end

    for (int i = 0; i < NEEDLE_MAX; i++) begin
      j = i + int'(eff_len) - NEEDLE_MAX;
      care_nxt[i]  = (j >= 0);
      align_nxt[i] = '0;
      if (j >= 0 && j < NeedleRegs) begin
        align_nxt[i] = fold_r ? fold_byte(nbytes[j[3:0]]) : nbytes[j[3:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_len_r <= '0;
      care_r    <= '0;
    end else begin
      eff_len_r <= eff_len;
      care_r    <= care_nxt;
    end
  end

  always_ff @(posedge clk) begin
    align_r <= align_nxt;
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic [ByteW-1:0] s1_byte_r;
  logic             s1_last_r;
  logic             in_fire;
  logic             go;

  // Advance the stage when the result register is free or being drained
  assign go           = s1_valid_r && (!out_if.valid || out_if.ready);
  assign in_if.ready  = !s1_valid_r || go;
  assign in_fire      = in_if.valid && in_if.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_if.haystack_byte;
      s1_last_r <= in_if.last_byte;
    end
  end

  // --------------------------------------------------------------------------
  // Search step: shift window, count, compare, decide on a result
  // --------------------------------------------------------------------------
  logic [ByteW-1:0]       win_r     [NEEDLE_MAX];
  logic [ByteW-1:0]       win_shift [NEEDLE_MAX];
  logic [OFFSET_BITS-1:0] count_r;
  logic [OFFSET_BITS-1:0] count_nxt;
  logic [OFFSET_BITS-1:0] count_inc;
  logic [OFFSET_BITS-1:0] len_ext;
  logic [OFFSET_BITS-1:0] offset;
  logic                   fin_r;
  logic                   fin_nxt;
  logic                   win_load;
  logic                   same;
  logic                   emit;
  logic                   hit;

  always_comb begin
    for (int i = 0; i < NEEDLE_MAX - 1; i++) begin
      win_shift[i] = win_r[i+1];
    end
    win_shift[NEEDLE_MAX-1] = fold_r ? fold_byte(s1_byte_r) : s1_byte_r;

    same = 1'b1;
    for (int i = 0; i < NEEDLE_MAX; i++) begin
      if (care_r[i] && (win_shift[i] != align_r[i])) begin
        same = 1'b0;
      end
    end

    len_ext   = OFFSET_BITS'(eff_len_r);
    count_inc = (count_r < CountMax) ? count_r + 1'b1 : count_r;
    offset    = count_inc - len_ext;

    emit      = 1'b0;
    hit       = 1'b0;
    win_load  = 1'b0;
    count_nxt = count_r;
    fin_nxt   = fin_r;

    if (go) begin
      if (fin_r) begin
        // Drop the rest of a finished search; its last byte rearms
        if (s1_last_r) begin
          count_nxt = '0;
          fin_nxt   = 1'b0;
        end
      end else begin
        if (eff_len_r == '0) begin
          // Empty needle: hit at the start of the search
          emit   = 1'b1;
          hit    = 1'b1;
          offset = '0;
        end else if (nul_r && s1_byte_r == AsciiNul) begin
          emit = 1'b1;
        end else begin
          win_load  = 1'b1;
          count_nxt = count_inc;
          if (count_inc >= len_ext && same) begin
            emit = 1'b1;
            hit  = 1'b1;
          end
          if (s1_last_r) begin
            emit = 1'b1;
          end
        end
        if (emit) begin
          if (s1_last_r) begin
            count_nxt = '0;
            fin_nxt   = 1'b0;
          end else begin
            fin_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      fin_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      fin_r   <= fin_nxt;
    end
  end

  // Window content outside the count is never compared, so it needs no clear
  always_ff @(posedge clk) begin
    if (win_load) begin
      win_r <= win_shift;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic                          found_r;
  logic [OffsetW-1:0]            offset_r;
  logic [OFFSET_BITS+OffsetW-1:0] offset_wide;

  assign offset_wide = {{OffsetW{1'b0}}, offset};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      found_r  <= hit;
      offset_r <= hit ? offset_wide[OffsetW-1:0] : '0;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.found        = found_r;
  assign out_if.match_offset = offset_r;

`ifndef NO_ASSERTIONS
  // A miss always reports offset zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !found_r |-> offset_r == '0)
    else $error("miss result with nonzero offset");

  // A result before the last byte marks the search finished
  a_fin_set: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !s1_last_r |=> fin_r)
    else $error("search not marked finished after early result");

  // Input stalls only when the stage is full and the result is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> s1_valid_r && out_valid_r && !out_if.ready)
    else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire
